/* rtl/lbm_pkg.sv */
// letterbox matte package: register map, reset values, geometry modes and
// sequencer states shared by the matte modules; no dependencies
`default_nettype none

package lbm_pkg;

  localparam int DIM_MAX_DEFAULT = 4096;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_TARGET_RATIO = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;
  localparam logic [1:0] REG_OPACITY      = 2'd3;

  localparam logic [15:0] RATIO_RESET   = 16'd0;
  localparam logic [12:0] WIDTH_RESET   = 13'd1920;
  localparam logic [12:0] HEIGHT_RESET  = 13'd1080;
  localparam logic [8:0]  OPACITY_RESET = 9'd256;
  localparam logic [8:0]  OPACITY_FULL  = 9'd256;

  localparam int PIX_W = 32;

  typedef enum logic [1:0] {
    GEO_NONE,
    GEO_LETTER,
    GEO_PILLAR
  } geo_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SCALE,
    ST_MODE,
    ST_DIV
  } geo_state_t;

endpackage

`default_nettype wire

/* rtl/lbm_geom.sv */
// letterbox matte geometry: works out bar kind and bar size from the
// configuration with a short sequencer and a serial divider; uses lbm_pkg
`default_nettype none

module lbm_geom #(
  parameter int MAX_DIMENSION = lbm_pkg::DIM_MAX_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  input  wire  [15:0]                           target_ratio,
  input  wire  [$clog2(MAX_DIMENSION+1)-1:0]    width_c,
  input  wire  [$clog2(MAX_DIMENSION+1)-1:0]    height_c,
  output logic                                  busy,
  output lbm_pkg::geo_mode_t                    mode,
  output logic [$clog2(MAX_DIMENSION+1)-1:0]    cut
);
  import lbm_pkg::*;

  localparam int DW    = $clog2(MAX_DIMENSION + 1);
  localparam int PRW   = 16 + DW;
  localparam int GW    = 26 + DW;
  localparam int RW    = 17;
  localparam int QW    = DW;
  localparam int NW    = 17 + DW;
  localparam int CNT_W = $clog2(QW);

  geo_state_t         state;
  geo_state_t         state_next;
  logic [PRW-1:0]     rh;
  logic [GW-1:0]      a_sc;
  logic [GW-1:0]      bw_sc;
  logic [GW-1:0]      bh_sc;
  logic [RW-1:0]      div_rem;
  logic [QW-1:0]      div_q;
  logic [RW-1:0]      div_d;
  logic [CNT_W-1:0]   div_cnt;

  logic               dims_zero;
  logic               is_letter;
  logic               is_pillar;
  logic [PRW-1:0]     w_shift;
  logic [PRW-1:0]     num_letter;
  logic [PRW-1:0]     num_pillar;
  logic [NW-1:0]      div_n;
  logic [PRW-1:0]     pillar_round;
  logic [RW:0]        div_t;
  logic               div_ge;
  logic [QW-1:0]      div_q_next;

  assign dims_zero  = (target_ratio == '0) || (width_c == '0) || (height_c == '0);
  assign is_letter  = {1'b0, a_sc} > ({1'b0, bw_sc} + {1'b0, bh_sc});
  assign is_pillar  = ({1'b0, a_sc} + {1'b0, bh_sc}) < {1'b0, bw_sc};
  assign w_shift    = PRW'({width_c, 12'd0});
  assign num_letter = rh - w_shift;
  assign num_pillar = w_shift - rh;
  assign div_n      = NW'(num_letter) + NW'({target_ratio, 1'b0}) - NW'(1);
  assign pillar_round = num_pillar + PRW'(8191);

  assign div_t      = {div_rem, div_q[QW-1]};
  assign div_ge     = div_t >= {1'b0, div_d};
  assign div_q_next = {div_q[QW-2:0], div_ge};

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PROD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  state_next = ST_IDLE;
      ST_PROD:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_MODE;
      ST_MODE: begin
        if (!dims_zero && is_letter && (num_letter > PRW'(target_ratio))) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_cnt == CNT_W'(QW - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_PROD;
    endcase
    if (start) begin
      state_next = ST_PROD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= GEO_NONE;
    end else if (!start) begin
      case (state)
        ST_MODE: begin
          if (dims_zero) begin
            mode <= GEO_NONE;
          end else if (is_letter) begin
            mode <= (num_letter > PRW'(target_ratio)) ? GEO_LETTER : GEO_NONE;
          end else if (is_pillar) begin
            mode <= (num_pillar > PRW'(4096)) ? GEO_PILLAR : GEO_NONE;
          end else begin
            mode <= GEO_NONE;
          end
        end
        default: mode <= mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_PROD: begin
        rh <= PRW'(target_ratio) * PRW'(height_c);
      end
      ST_SCALE: begin
        a_sc  <= GW'(rh) * GW'(1000);
        bw_sc <= GW'({GW'(width_c) * GW'(1000), 12'd0});
        bh_sc <= GW'({height_c, 12'd0});
      end
      ST_MODE: begin
        div_rem <= div_n[NW-1:QW];
        div_q   <= div_n[QW-1:0];
        div_d   <= {target_ratio, 1'b0};
        div_cnt <= '0;
        cut     <= DW'(pillar_round >> 13);
      end
      ST_DIV: begin
        div_rem <= div_ge ? RW'(div_t - {1'b0, div_d}) : div_t[RW-1:0];
        div_q   <= div_q_next;
        div_cnt <= div_cnt + CNT_W'(1);
        if (div_cnt == CNT_W'(QW - 1)) begin
          cut <= div_q_next;
        end
      end
      default: begin
        rh <= rh;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/lbm_pixel.sv */
// letterbox matte pixel path: position counters, input register, bar test
// and darkening into the result register; uses lbm_pkg
`default_nettype none

module lbm_pixel #(
  parameter int MAX_DIMENSION = lbm_pkg::DIM_MAX_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   busy,
  input  lbm_pkg::geo_mode_t                    mode,
  input  wire  [$clog2(MAX_DIMENSION+1)-1:0]    cut,
  input  wire  [$clog2(MAX_DIMENSION+1)-1:0]    width_c,
  input  wire  [$clog2(MAX_DIMENSION+1)-1:0]    height_c,
  input  wire  [8:0]                            keep,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [lbm_pkg::PIX_W-1:0]             s_axis_tdata,
  input  wire  [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [lbm_pkg::PIX_W-1:0]             m_axis_tdata,
  output logic [0:0]                            m_axis_tuser
);
  import lbm_pkg::*;

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int PW = $clog2(MAX_DIMENSION);

  logic [PW-1:0]     col;
  logic [PW-1:0]     row;
  logic [PW-1:0]     col_next;
  logic [PW-1:0]     row_next;
  logic              s1_valid;
  logic [PW-1:0]     s1_x;
  logic [PW-1:0]     s1_y;
  logic [PIX_W-1:0]  s1_pix;

  logic              accept;
  logic              s1_move;
  logic [PW-1:0]     x0;
  logic [PW-1:0]     y0;
  logic [DW-1:0]     w_adv;
  logic [DW-1:0]     h_adv;
  logic [DW-1:0]     x_inc;
  logic [DW-1:0]     y_inc;
  logic [DW:0]       x_e;
  logic [DW:0]       y_e;
  logic [DW:0]       cut_e;
  logic              bar;
  logic [16:0]       prod_r;
  logic [16:0]       prod_g;
  logic [16:0]       prod_b;
  logic [PIX_W-1:0]  pix_out;

  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !busy && (!s1_valid || s1_move);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // start of frame restarts the raster
  assign x0    = s_axis_tuser[0] ? '0 : col;
  assign y0    = s_axis_tuser[0] ? '0 : row;
  assign w_adv = (width_c == '0) ? DW'(1) : width_c;
  assign h_adv = (height_c == '0) ? DW'(1) : height_c;
  assign x_inc = DW'(x0) + DW'(1);
  assign y_inc = DW'(y0) + DW'(1);

  always_comb begin
    if (x_inc >= w_adv) begin
      col_next = '0;
      row_next = (y_inc >= h_adv) ? '0 : PW'(y_inc);
    end else begin
      col_next = PW'(x_inc);
      row_next = y0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x   <= x0;
      s1_y   <= y0;
      s1_pix <= s_axis_tdata;
    end
  end

  assign x_e   = (DW+1)'(s1_x);
  assign y_e   = (DW+1)'(s1_y);
  assign cut_e = (DW+1)'(cut);

  always_comb begin
    case (mode)
      GEO_LETTER: bar = (y_e < cut_e) || ((y_e + cut_e) >= (DW+1)'(height_c));
      GEO_PILLAR: bar = (x_e < cut_e) || ((x_e + cut_e) >= (DW+1)'(width_c));
      default:    bar = 1'b0;
    endcase
  end

  assign prod_r = {9'd0, s1_pix[7:0]}   * {8'd0, keep};
  assign prod_g = {9'd0, s1_pix[15:8]}  * {8'd0, keep};
  assign prod_b = {9'd0, s1_pix[23:16]} * {8'd0, keep};

  assign pix_out = bar ? {s1_pix[31:24], prod_b[15:8], prod_g[15:8], prod_r[15:8]}
                       : s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_axis_tdata <= pix_out;
      m_axis_tuser <= bar;
    end
  end

endmodule

`default_nettype wire

/* rtl/letterbox_matte_pixel_stream.sv */
// letterbox / pillarbox matte on an rgba pixel stream: register port and
// top level; uses lbm_pkg, lbm_geom and lbm_pixel
//
//   port group   dir   contents
//   s_axis_*     in    pixel items, frame_start in tuser
//   m_axis_*     out   matted pixel items, in_bar in tuser
//   apb          in    target_ratio, frame_width, frame_height, opacity
//
// one item per cycle while the geometry sequencer is idle and results are taken;
// each item passes through the input register and the result register. after
// reset and after every register write the geometry sequencer steps through its
// product, scale and mode states, and through the serial divider as well when a
// letterbox bar height needs it, with s_axis_tready low.
// a stalled result holds while one more item waits in the input register.
`default_nettype none

module letterbox_matte_pixel_stream #(
  parameter int MAX_DIMENSION = lbm_pkg::DIM_MAX_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  input  wire  [lbm_pkg::PIX_W-1:0]         s_axis_tdata,
  // frame_start [0]
  input  wire  [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // out_red [7:0], out_green [15:8], out_blue [23:16], out_alpha [31:24]
  output logic [lbm_pkg::PIX_W-1:0]         m_axis_tdata,
  // in_bar [0]
  output logic [0:0]                        m_axis_tuser,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [lbm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire  [lbm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lbm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import lbm_pkg::*;

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int CW = (DW > 13) ? DW : 13;

  logic [15:0]   target_ratio;
  logic [12:0]   frame_width;
  logic [12:0]   frame_height;
  logic [8:0]    opacity;

  logic          cfg_wr;
  logic [CW-1:0] w_ext;
  logic [CW-1:0] h_ext;
  logic [DW-1:0] width_c;
  logic [DW-1:0] height_c;
  logic [8:0]    keep;
  logic          geo_busy;
  geo_mode_t     geo_mode;
  logic [DW-1:0] geo_cut;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_ratio <= RATIO_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      opacity      <= OPACITY_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TARGET_RATIO: target_ratio <= pwdata[15:0];
        REG_FRAME_WIDTH:  frame_width  <= pwdata[12:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[12:0];
        REG_OPACITY:      opacity      <= pwdata[8:0];
        default:          target_ratio <= target_ratio;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TARGET_RATIO: prdata = CFG_DATA_W'(target_ratio);
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height);
      REG_OPACITY:      prdata = CFG_DATA_W'(opacity);
      default:          prdata = '0;
    endcase
  end

  // sizes above the maximum count as the maximum
  assign w_ext    = CW'(frame_width);
  assign h_ext    = CW'(frame_height);
  assign width_c  = (w_ext > CW'(MAX_DIMENSION)) ? DW'(MAX_DIMENSION) : DW'(w_ext);
  assign height_c = (h_ext > CW'(MAX_DIMENSION)) ? DW'(MAX_DIMENSION) : DW'(h_ext);
  assign keep     = (opacity > OPACITY_FULL) ? 9'd0 : (OPACITY_FULL - opacity);

  lbm_geom #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_geom (
    .clk          (clk),
    .rst          (rst),
    .start        (cfg_wr),
    .target_ratio (target_ratio),
    .width_c      (width_c),
    .height_c     (height_c),
    .busy         (geo_busy),
    .mode         (geo_mode),
    .cut          (geo_cut)
  );

  lbm_pixel #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_pixel (
    .clk           (clk),
    .rst           (rst),
    .busy          (geo_busy),
    .mode          (geo_mode),
    .cut           (geo_cut),
    .width_c       (width_c),
    .height_c      (height_c),
    .keep          (keep),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !s_axis_tready)
    else $error("input taken right after a register write");

  a_off_no_bars: assert property (@(posedge clk) disable iff (rst)
    (!geo_busy && target_ratio == '0) |-> geo_mode == GEO_NONE)
    else $error("bars active with matte off");

  a_bar_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!geo_busy && geo_mode != GEO_NONE) |-> geo_cut != '0)
    else $error("bar mode with zero bar size");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
// self-checking bench for letterbox_matte_pixel_stream: random bursts of rgba items through
// the stream ports, register settings over apb, and a bit-exact matte predictor
// depends on rtl/lbm_pkg.sv and rtl/letterbox_matte_pixel_stream.sv
`default_nettype none

module testbench;
  import lbm_pkg::*;

  localparam int          MAX_DIM    = DIM_MAX_DEFAULT;
  localparam int          LONG_HOLD  = 300;
  localparam int unsigned CYCLE_CAP  = 300000;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] alpha;
    bit       frame_start;
  } pixel_item_t;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] alpha;
    bit       in_bar;
  } matte_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire  [PIX_W-1:0]      m_axis_tdata;
  wire  [0:0]            m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  wire  [CFG_DATA_W-1:0] prdata;
  wire                   pready;

  letterbox_matte_pixel_stream u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and raster position of the predictor
  bit [15:0] cfg_ratio   = RATIO_RESET;
  bit [12:0] cfg_width   = WIDTH_RESET;
  bit [12:0] cfg_height  = HEIGHT_RESET;
  bit [8:0]  cfg_opacity = OPACITY_RESET;
  bit [11:0] col_pos = '0;
  bit [11:0] row_pos = '0;

  pixel_item_t   pending_pixels[$];
  matte_result_t expected_pixels[$];
  pixel_item_t   in_flight;

  int          burst_left = 1;
  int          gap_left = 0;
  int          ready_left = 0;
  bit          ready_phase = 1'b0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          bar_results = 0;
  int          mismatches = 0;
  int          settings_used = 0;
  int unsigned cycles = 0;

  function automatic longint unsigned clamp_dim(input bit [12:0] d);
    return (d > MAX_DIM) ? longint'(MAX_DIM) : longint'(d);
  endfunction

  function automatic bit in_matte_bar(input longint unsigned x, input longint unsigned y);
    longint unsigned r, w, h, num, c;
    r = cfg_ratio;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    if (r == 0 || w == 0 || h == 0) return 1'b0;
    // letterbox: bars on top and bottom rows
    if (1000 * r * h > 4096000 * w + 4096 * h) begin
      num = r * h - 4096 * w;
      if (num <= r) return 1'b0;
      c = (num + 2 * r - 1) / (2 * r);
      return (y < c) || (y + c >= h);
    end
    // pillarbox: bars on left and right columns
    if (1000 * r * h + 4096 * h < 4096000 * w) begin
      num = 4096 * w - r * h;
      if (num <= 4096) return 1'b0;
      c = (num + 8191) / 8192;
      return (x < c) || (x + c >= w);
    end
    return 1'b0;
  endfunction

  function automatic void predict_matte(input pixel_item_t p);
    matte_result_t e;
    int unsigned   keep, wc, hc;
    if (p.frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    e.in_bar = in_matte_bar(col_pos, row_pos);
    keep = 256 - ((cfg_opacity > OPACITY_FULL) ? 256 : int'(cfg_opacity));
    e.red   = e.in_bar ? 8'((p.red * keep) >> 8) : p.red;
    e.green = e.in_bar ? 8'((p.green * keep) >> 8) : p.green;
    e.blue  = e.in_bar ? 8'((p.blue * keep) >> 8) : p.blue;
    e.alpha = p.alpha;
    expected_pixels.push_back(e);
    wc = 32'(clamp_dim(cfg_width));
    hc = 32'(clamp_dim(cfg_height));
    if (wc == 0) wc = 1;
    if (hc == 0) hc = 1;
    if (col_pos + 1 >= wc) begin
      col_pos = '0;
      row_pos = (row_pos + 1 >= hc) ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos = col_pos + 12'd1;
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, field, got,
             want);
  endtask

  function automatic void push_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b,
                                     input bit [7:0] a, input bit s);
    pixel_item_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.frame_start = s;
    pending_pixels.push_back(p);
  endfunction

  function automatic bit [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 11))
      0: return 1;
      1: return MAX_DIM;
      2: return $urandom_range(0, 1) ? 8191 : 0;
      3: return $urandom_range(25, 300);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // sender: bursts of items from the pending queue with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_matte(in_flight);
        items_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        in_flight = pending_pixels.pop_front();
        s_axis_tdata <= {in_flight.alpha, in_flight.blue, in_flight.green, in_flight.red};
        s_axis_tuser <= in_flight.frame_start;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 5) == 0) begin
          burst_left = $urandom_range(40, 100);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 30 && pending_pixels.size() > 40) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (ready_left > 0) begin
      ready_left--;
      m_axis_tready <= ready_phase;
    end else begin
      ready_phase = !ready_phase;
      if (ready_phase)
        ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(0, 40);
      else
        ready_left = $urandom_range(0, 3);
      m_axis_tready <= ready_phase;
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    matte_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser[0] === 1'b1) bar_results++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[7:0] !== want.red)
          report_mismatch("out_red", 32'(m_axis_tdata[7:0]), 32'(want.red));
        if (m_axis_tdata[15:8] !== want.green)
          report_mismatch("out_green", 32'(m_axis_tdata[15:8]), 32'(want.green));
        if (m_axis_tdata[23:16] !== want.blue)
          report_mismatch("out_blue", 32'(m_axis_tdata[23:16]), 32'(want.blue));
        if (m_axis_tdata[31:24] !== want.alpha)
          report_mismatch("out_alpha", 32'(m_axis_tdata[31:24]), 32'(want.alpha));
        if (m_axis_tuser[0] !== want.in_bar)
          report_mismatch("in_bar", 32'(m_axis_tuser), 32'(want.in_bar));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    // let any geometry pass from an earlier write finish first
    repeat (2) @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TARGET_RATIO: cfg_ratio = value[15:0];
      REG_FRAME_WIDTH:  cfg_width = value[12:0];
      REG_FRAME_HEIGHT: cfg_height = value[12:0];
      REG_OPACITY:      cfg_opacity = value[8:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned ratio, input int unsigned width,
                           input int unsigned height, input int unsigned opac);
    wait_idle();
    write_reg(REG_TARGET_RATIO, ratio);
    write_reg(REG_FRAME_WIDTH, width);
    write_reg(REG_FRAME_HEIGHT, height);
    write_reg(REG_OPACITY, opac);
    settings_used++;
    @(negedge clk);
  endtask

  task automatic queue_random_items(input int n, input int unsigned frame_len);
    bit s;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      s = (i % frame_len) == 0;
      // occasional broken framing
      if ($urandom_range(0, 23) == 0) s = 1'($urandom_range(0, 1));
      push_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(), s);
    end
  endtask

  initial begin : stimulus
    int unsigned w, h, we, he, r, op;
    int          rs;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // matte off at reset settings, extreme and alternating pixel values
    @(negedge clk);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    push_pixel(8'ha5, 8'h5a, 8'hc3, 8'h3c, 1'b0);

    // letterbox bar of exactly half a line: no bars
    configure(8192, 4, 3, 256);
    push_pixel(8'hff, 8'h80, 8'h01, 8'h7f, 1'b1);
    push_pixel(8'hff, 8'hff, 8'hff, 8'h00, 1'b0);

    // widest ratio, every row in a bar, zero opacity keeps colour
    configure(65535, 2, 4, 0);
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    push_pixel(8'h5a, 8'ha5, 8'h0f, 8'hf0, 1'b0);
    push_pixel(8'h01, 8'h80, 8'hfe, 8'h11, 1'b0);

    // pillarbox on an odd width, opacity beyond full saturates
    configure(4096, 7, 2, 300);
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    for (int i = 0; i < 6; i++) push_pixel(8'hff, 8'h80, 8'h01, 8'ha5, 1'b0);

    // a zero dimension switches the matte off, also beside an oversized one
    configure(1, 0, 8191, 256);
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    push_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
    push_pixel(8'hff, 8'h00, 8'hff, 8'h00, 1'b0);
    configure(40000, 8191, 0, 128);
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    push_pixel(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);

    // random settings, mostly small frames so that bars show in rows and columns
    for (int k = 0; k < 14; k++) begin
      w = pick_dim();
      h = pick_dim();
      if (k == 0) begin
        w = $urandom_range(2, 12);
        h = $urandom_range(2, 12);
      end
      we = (w > MAX_DIM) ? MAX_DIM : ((w == 0) ? 1 : w);
      he = (h > MAX_DIM) ? MAX_DIM : ((h == 0) ? 1 : h);
      case ($urandom_range(0, 9))
        0: r = 0;
        1: r = 65535;
        2, 3: r = $urandom_range(1, 65535);
        default: begin
          // close to the frame aspect, both sides of the tolerance
          rs = int'((we * 4096) / he) + int'($urandom_range(0, 24)) - 12;
          if ($urandom_range(0, 2) == 0) rs = rs + int'($urandom_range(0, 4000)) - 2000;
          r = (rs < 0) ? 0 : ((rs > 65535) ? 65535 : rs);
        end
      endcase
      case ($urandom_range(0, 5))
        0: op = 0;
        1: op = 256;
        2: op = 511;
        default: op = $urandom_range(0, 511);
      endcase
      configure(r, w, h, op);
      queue_random_items((k == 0) ? 150 : $urandom_range(60, 110), we * he);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("%0d items checked over %0d register settings, %0d of them inside a bar",
             items_sent, settings_used, bar_results);
    $display("receiver held off once for %0d cycles; %0d mismatches", LONG_HOLD, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
